// ----- hdl/japanese_text_encoding_guesser_top_macros.svh -----
// Assertion macros for the encoding guesser checker.
// Included by the checker file; holds nothing but macro definitions.
`ifndef JAPANESE_TEXT_ENCODING_GUESSER_TOP_MACROS_SVH
`define JAPANESE_TEXT_ENCODING_GUESSER_TOP_MACROS_SVH

// Property checked on the rising clock edge, switched off while reset is high.
`define JTEG_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define JTEG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/jteg_pkg.sv -----
// Package for the Japanese text encoding guesser: codes, weights, types and
// the per-position scoring function. Depends on nothing.
package jteg_pkg;

   localparam int ScoreBitsDef = 32;
   localparam int IncW         = 12;

   // Byte values with a meaning of their own
   localparam logic [7:0] ByteEsc = 8'h1b;
   localparam logic [7:0] ByteSs2 = 8'h8e;
   localparam logic [7:0] ByteSs3 = 8'h8f;

   // Score weights
   localparam logic [IncW-1:0] WtOne     = IncW'(1);
   localparam logic [IncW-1:0] WtKana    = IncW'(16'h10 / 2 - 1);
   localparam logic [IncW-1:0] WtPair    = IncW'(16'h10);
   localparam logic [IncW-1:0] WtBad     = IncW'(16'h100);
   localparam logic [IncW-1:0] WtTen     = IncW'(10);
   localparam logic [IncW-1:0] WtU8Three = IncW'(15);
   localparam logic [IncW-1:0] WtHundred = IncW'(100);
   localparam logic [IncW-1:0] WtU8Bad   = IncW'(1000);

   typedef enum logic [3:0] {
      EncUnknown = 4'd0,
      EncAscii   = 4'd1,
      EncJis     = 4'd2,
      EncUtf16le = 4'd3,
      EncUtf16be = 4'd4,
      EncUtf8Bom = 4'd5,
      EncSjis    = 4'd6,
      EncEucjp   = 4'd7,
      EncUtf8    = 4'd8
   } jteg_enc_type;

   // Per-scanner skip counts and kana run lengths
   typedef struct packed {
      logic [1:0] skip_sj;
      logic [1:0] skip_eu;
      logic [1:0] skip_u8;
      logic [1:0] kana_sj;
      logic [1:0] kana_eu;
   } jteg_scan_type;

   // Score increments gathered over the positions of one beat
   typedef struct packed {
      logic [IncW-1:0] s_sj;
      logic [IncW-1:0] b_sj;
      logic [IncW-1:0] s_eu;
      logic [IncW-1:0] b_eu;
      logic [IncW-1:0] s_u8;
      logic [IncW-1:0] b_u8;
   } jteg_inc_type;

   typedef struct packed {
      jteg_scan_type st;
      jteg_inc_type  inc;
   } jteg_pos_type;

   // What the verdict stage needs besides the scores
   typedef struct packed {
      logic [2:0][7:0] first;
      logic [1:0]      seen;
      logic            high;
      logic            esc;
   } jteg_text_type;

   function automatic logic is_kana(input logic [7:0] c);
      return c inside {[8'ha0:8'hdf]};
   endfunction

   function automatic logic is_euc(input logic [7:0] c);
      return c inside {[8'ha1:8'hfe]};
   endfunction

   function automatic logic is_sj_lead(input logic [7:0] c);
      return c inside {[8'h81:8'h9f], [8'he0:8'hfc]};
   endfunction

   function automatic logic is_sj_trail(input logic [7:0] c);
      return (c inside {[8'h40:8'hfc]}) && (c != 8'h7f);
   endfunction

   function automatic logic is_u8_trail(input logic [7:0] c);
      return c inside {[8'h80:8'hbf]};
   endfunction

   function automatic logic [1:0] kana_bump(input logic [1:0] k);
      return (k < 2'd2) ? k + 2'd1 : k;
   endfunction

   // Score one position; avail counts the following bytes present (0..2)
   function automatic jteg_pos_type score_pos(input jteg_pos_type acc,
                                              input logic [7:0] c,
                                              input logic [7:0] n1,
                                              input logic [7:0] n2,
                                              input logic [1:0] avail);
      jteg_pos_type r;
      r = acc;

      // Shift_JIS scanner
      if (acc.st.skip_sj != 2'd0) begin
         r.st.skip_sj = acc.st.skip_sj - 2'd1;
      end else begin
         if (c == ByteSs2 && avail >= 2'd2 && n2 == ByteSs2 && is_kana(n1))
            r.inc.b_sj = r.inc.b_sj + WtOne;
         if (is_kana(c)) begin
            r.inc.s_sj = r.inc.s_sj + WtKana;
            r.st.kana_sj = kana_bump(acc.st.kana_sj);
         end else begin
            if (acc.st.kana_sj == 2'd1)
               r.inc.b_sj = r.inc.b_sj + WtOne;
            r.st.kana_sj = 2'd0;
            if (is_sj_lead(c)) begin
               if (avail >= 2'd1) begin
                  if (is_sj_trail(n1)) begin
                     r.inc.s_sj = r.inc.s_sj + WtPair;
                     r.st.skip_sj = 2'd1;
                  end else begin
                     r.inc.b_sj = r.inc.b_sj + WtBad;
                  end
               end
            end else if (c[7]) begin
               r.inc.b_sj = r.inc.b_sj + WtBad;
            end
         end
      end

      // EUC-JP scanner
      if (acc.st.skip_eu != 2'd0) begin
         r.st.skip_eu = acc.st.skip_eu - 2'd1;
      end else if (c == ByteSs2) begin
         if (avail >= 2'd1) begin
            if (is_kana(n1)) begin
               r.inc.s_eu = r.inc.s_eu + WtTen;
               r.st.skip_eu = 2'd1;
               r.st.kana_eu = kana_bump(acc.st.kana_eu);
            end else begin
               r.inc.b_eu = r.inc.b_eu + WtBad;
            end
         end
      end else begin
         if (acc.st.kana_eu == 2'd1)
            r.inc.b_eu = r.inc.b_eu + WtOne;
         r.st.kana_eu = 2'd0;
         if (is_euc(c)) begin
            if (avail >= 2'd1) begin
               if (is_euc(n1)) begin
                  r.inc.s_eu = r.inc.s_eu + WtPair;
                  r.st.skip_eu = 2'd1;
               end else begin
                  r.inc.b_eu = r.inc.b_eu + WtBad;
               end
            end
         end else if (c == ByteSs3) begin
            if (avail >= 2'd2) begin
               if (is_euc(n1) && is_euc(n2)) begin
                  r.inc.s_eu = r.inc.s_eu + WtPair;
                  r.st.skip_eu = 2'd2;
               end else begin
                  r.inc.b_eu = r.inc.b_eu + WtHundred;
               end
            end
         end else if (c[7]) begin
            r.inc.b_eu = r.inc.b_eu + WtBad;
         end
      end

      // UTF-8 scanner
      if (acc.st.skip_u8 != 2'd0) begin
         r.st.skip_u8 = acc.st.skip_u8 - 2'd1;
      end else if (c inside {[8'hc0:8'hdf]}) begin
         if (avail >= 2'd1) begin
            if (is_u8_trail(n1)) begin
               r.inc.s_u8 = r.inc.s_u8 + WtTen;
               r.st.skip_u8 = 2'd1;
            end else begin
               r.inc.b_u8 = r.inc.b_u8 + WtHundred;
            end
         end
      end else if (c inside {[8'he0:8'hef]}) begin
         if (avail >= 2'd2) begin
            if (is_u8_trail(n1) && is_u8_trail(n2)) begin
               r.inc.s_u8 = r.inc.s_u8 + WtU8Three;
               r.st.skip_u8 = 2'd2;
            end else begin
               r.inc.b_u8 = r.inc.b_u8 + WtU8Bad;
            end
         end
      end else if (c[7]) begin
         r.inc.b_u8 = r.inc.b_u8 + WtU8Bad;
      end
      return r;
   endfunction

endpackage

// ----- hdl/jteg_judge.sv -----
// Verdict stage of the encoding guesser: holds a finished text's scores,
// compares net scores and drives the result register. Depends on jteg_pkg.
module jteg_judge import jteg_pkg::*; #(
   parameter int SCORE_BITS = ScoreBitsDef
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load_valid,
   output logic                          load_ready,
   input  jteg_text_type                 load_text,
   input  logic [5:0][SCORE_BITS-1:0]    load_score,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [3:0]                    rsp_encoding
);

   localparam int SumW = SCORE_BITS + 1;

   logic                       jdg_valid_ff, jdg_valid_in;
   jteg_text_type              text_ff;
   logic [5:0][SCORE_BITS-1:0] score_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   jteg_enc_type               enc_ff, enc_in;
   logic                       jdg_move;
   logic [SumW-1:0]            se_l, se_r, su_l, su_r, eu_l, eu_r;
   logic                       se_gt, se_lt, su_gt, su_lt, eu_gt, eu_lt;

   // Move on when the result register is free or being emptied
   assign jdg_move   = jdg_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign load_ready = !jdg_valid_ff || jdg_move;

   assign jdg_valid_in = load_valid || (jdg_valid_ff && !jdg_move);
   assign rsp_valid_in = jdg_move || (rsp_valid_ff && !rsp_ready);

   // Net comparisons as (score_a + bad_b) against (bad_a + score_b)
   always_comb begin
      se_l = SumW'(score_ff[0]) + SumW'(score_ff[3]);
      se_r = SumW'(score_ff[1]) + SumW'(score_ff[2]);
      su_l = SumW'(score_ff[0]) + SumW'(score_ff[5]);
      su_r = SumW'(score_ff[1]) + SumW'(score_ff[4]);
      eu_l = SumW'(score_ff[2]) + SumW'(score_ff[5]);
      eu_r = SumW'(score_ff[3]) + SumW'(score_ff[4]);
      se_gt = se_l > se_r;
      se_lt = se_l < se_r;
      su_gt = su_l > su_r;
      su_lt = su_l < su_r;
      eu_gt = eu_l > eu_r;
      eu_lt = eu_l < eu_r;
   end

   // Judge: byte-order mark, then plain ASCII or JIS, then net scores
   always_comb begin
      enc_in = EncUnknown;
      if (text_ff.seen >= 2'd2 && text_ff.first[0] == 8'hff && text_ff.first[1] == 8'hfe) begin
         enc_in = EncUtf16le;
      end else if (text_ff.seen >= 2'd2 && text_ff.first[0] == 8'hfe &&
                   text_ff.first[1] == 8'hff) begin
         enc_in = EncUtf16be;
      end else if (text_ff.seen == 2'd3 && text_ff.first[0] == 8'hef &&
                   text_ff.first[1] == 8'hbb && text_ff.first[2] == 8'hbf) begin
         enc_in = EncUtf8Bom;
      end else if (!text_ff.high) begin
         enc_in = text_ff.esc ? EncJis : EncAscii;
      end else if (se_gt && su_gt) begin
         enc_in = EncSjis;
      end else if (se_gt && su_lt) begin
         enc_in = EncUtf8;
      end else if (se_lt && eu_gt) begin
         enc_in = EncEucjp;
      end else if (se_lt && eu_lt) begin
         enc_in = EncUtf8;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         jdg_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         jdg_valid_ff <= jdg_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the finished text and the verdict
   always_ff @(posedge clock) begin
      if (load_valid && load_ready) begin
         text_ff  <= load_text;
         score_ff <= load_score;
      end
      if (jdg_move) begin
         enc_ff <= enc_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_encoding = enc_ff;

endmodule

// ----- hdl/japanese_text_encoding_guesser_top.sv -----
// Japanese text encoding guesser, top level.
// Takes one byte a beat on req_, gives one encoding code a text on rsp_.
// Byte beats carry req_data_byte and req_last; req_last marks the final
// byte of a text (a text holds at least one byte). Only the final beat of
// a text yields a result beat, rsp_encoding.
// Once the two-byte window is full, each accepted byte has the oldest
// window byte scored in the cycle it is accepted: the three scanners run
// back to back in one pass, and on the final byte the window is flushed in
// the same pass. The finished scores move to a verdict register, are
// compared there, and the code goes through the result register to rsp_valid.
// Throughput is one byte per cycle while req_ready is high; a new text may
// start in the cycle after the last byte of the one before.
// Reset clears the scanning state and both result stages. While the
// receiver holds rsp_ready low, one more finished text waits in the
// verdict register and bytes keep flowing; req_ready drops only when both
// are full.
// Depends on jteg_pkg and jteg_judge.
module japanese_text_encoding_guesser_top import jteg_pkg::*; #(
   parameter int SCORE_BITS = ScoreBitsDef
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_encoding
);

   localparam int SumW = SCORE_BITS + 1;

   logic [2:0][7:0]            first_ff, first_in;
   logic [1:0]                 seen_ff, seen_in;
   logic [1:0][7:0]            win_ff, win_in;
   logic                       high_ff, high_in;
   logic                       esc_ff, esc_in;
   jteg_scan_type              scan_ff, scan_in;
   logic [5:0][SCORE_BITS-1:0] score_ff, score_in;

   logic                       accept;
   logic                       load_ready;
   logic [1:0]                 held;
   jteg_pos_type               p0, p1, p3;
   logic [5:0][IncW-1:0]       inc;
   logic [SumW-1:0]            sum;
   jteg_text_type              text;

   assign accept    = req_valid && req_ready;
   assign req_ready = load_ready;

   // Score this beat and, on the final byte, flush the window
   always_comb begin
      first_in = first_ff;
      if (seen_ff != 2'd3)
         first_in[seen_ff] = req_data_byte;
      seen_in = (seen_ff == 2'd3) ? seen_ff : seen_ff + 2'd1;
      high_in = high_ff | req_data_byte[7];
      esc_in  = esc_ff | (req_data_byte == ByteEsc);
      held    = seen_ff[1] ? 2'd2 : seen_ff;

      p0 = '{st: scan_ff, inc: '0};
      win_in = win_ff;
      if (held == 2'd2) begin
         p1 = score_pos(p0, win_ff[0], win_ff[1], req_data_byte, 2'd2);
         win_in[0] = win_ff[1];
         win_in[1] = req_data_byte;
      end else begin
         p1 = p0;
         win_in[held[0]] = req_data_byte;
      end

      p3 = p1;
      if (req_last) begin
         if (held != 2'd0) begin
            p3 = score_pos(score_pos(p1, win_in[0], win_in[1], 8'h00, 2'd1),
                           win_in[1], 8'h00, 8'h00, 2'd0);
         end else begin
            p3 = score_pos(p1, win_in[0], 8'h00, 8'h00, 2'd0);
         end
      end
      scan_in = p3.st;

      inc = {p3.inc.b_u8, p3.inc.s_u8, p3.inc.b_eu, p3.inc.s_eu,
             p3.inc.b_sj, p3.inc.s_sj};
      // Saturating add per counter
      for (int k = 0; k < 6; k++) begin
         sum = SumW'(score_ff[k]) + SumW'(inc[k]);
         score_in[k] = sum[SCORE_BITS] ? {SCORE_BITS{1'b1}} : sum[SCORE_BITS-1:0];
      end

      text = '{first: first_in, seen: seen_in, high: high_in, esc: esc_in};
   end

   // Advance the scanning state; clear it after the final byte
   always_ff @(posedge clock) begin
      if (reset || (accept && req_last)) begin
         first_ff <= '0;
         seen_ff  <= '0;
         win_ff   <= '0;
         high_ff  <= 1'b0;
         esc_ff   <= 1'b0;
         scan_ff  <= '0;
         score_ff <= '0;
      end else if (accept) begin
         first_ff <= first_in;
         seen_ff  <= seen_in;
         win_ff   <= win_in;
         high_ff  <= high_in;
         esc_ff   <= esc_in;
         scan_ff  <= scan_in;
         score_ff <= score_in;
      end
   end

   jteg_judge #(
      .SCORE_BITS (SCORE_BITS)
   ) u_judge (
      .clock        (clock),
      .reset        (reset),
      .load_valid   (accept && req_last),
      .load_ready   (load_ready),
      .load_text    (text),
      .load_score   (score_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_encoding (rsp_encoding)
   );

endmodule

// ----- hdl/jteg_checker.sv -----
// Port checker for the encoding guesser, bound to the top level.
// Depends on the assertion macro header.
`include "japanese_text_encoding_guesser_top_macros.svh"

module jteg_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_encoding
);

   // Hold a stalled result beat
   `JTEG_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_encoding), "stalled result changed")

   // Codes stay within the defined set
   `JTEG_ASSERT(a_enc_range, clock, reset, rsp_valid |-> rsp_encoding <= 4'd8, "encoding code out of range")

   // A fresh result follows an accepted final byte via the verdict and result registers
   `JTEG_ASSERT(a_rsp_cause, clock, reset, $rose(rsp_valid) |-> $past(req_valid && req_ready && req_last, 2), "result without final byte")

   // Reset drops the result channel
   `JTEG_ASSERT_ALWAYS(a_rsp_reset, clock, $past(reset) |-> !rsp_valid, "result valid after reset")

endmodule

bind japanese_text_encoding_guesser_top jteg_checker u_jteg_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_ready    (req_ready),
   .req_last     (req_last),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_encoding (rsp_encoding)
);

// ----- tb/japanese_text_encoding_guesser_top_tb.sv -----
// Testbench for the Japanese text encoding guesser top level.
// Drives byte beats on req_, predicts each text's encoding code and checks rsp_.
// Depends on jteg_pkg for the encoding codes and on the top-level RTL.
`timescale 1ns / 100ps

module japanese_text_encoding_guesser_top_tb;
   import jteg_pkg::*;

   localparam int SB = 32;
   localparam logic [63:0] SAT_MAX = 64'hffff_ffff;
   localparam int LIMIT = 2000000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [3:0] rsp_encoding;

   japanese_text_encoding_guesser_top #(.SCORE_BITS(SB)) i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_data_byte(req_data_byte), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_encoding(rsp_encoding)
   );

   always #5 clock = ~clock;

   // Predictor state for the text in flight
   logic [7:0]  head_bytes [3];
   int          n_seen;
   logic [7:0]  win [2];
   bit          any_high, any_esc;
   int          skip_sj, skip_eu, skip_u8, run_sj, run_eu;
   logic [63:0] sc [6];   // score SJ, penalty SJ, score EU, penalty EU, score U8, penalty U8

   jteg_enc_type expected_codes [$];
   int  errors = 0;
   int  cycles = 0;
   bit  burst_mode = 1'b1;
   int  stall_mode = 0;

   task automatic clear_text();
      for (int k = 0; k < 3; k++) head_bytes[k] = 8'h00;
      win[0] = 8'h00; win[1] = 8'h00;
      n_seen = 0; any_high = 0; any_esc = 0;
      skip_sj = 0; skip_eu = 0; skip_u8 = 0; run_sj = 0; run_eu = 0;
      for (int k = 0; k < 6; k++) sc[k] = 64'd0;
   endtask

   function automatic logic [63:0] sat_add(input logic [63:0] c, input logic [63:0] v);
      return (c > SAT_MAX - v) ? SAT_MAX : c + v;
   endfunction

   function automatic bit kana_b(input logic [7:0] c); return c >= 8'ha0 && c <= 8'hdf; endfunction
   function automatic bit euc_b(input logic [7:0] c); return c >= 8'ha1 && c <= 8'hfe; endfunction
   function automatic bit u8t_b(input logic [7:0] c); return c >= 8'h80 && c <= 8'hbf; endfunction

   // Score one window position against its available followers
   task automatic score_position(input logic [7:0] c, input logic [7:0] n1,
                                 input logic [7:0] n2, input int avail);
      if (skip_sj > 0) begin
         skip_sj--;
      end else begin
         if (c == 8'h8e && avail >= 2 && n2 == 8'h8e && kana_b(n1)) sc[1] = sat_add(sc[1], 1);
         if (kana_b(c)) begin
            sc[0] = sat_add(sc[0], 7);
            if (run_sj < 2) run_sj++;
         end else begin
            if (run_sj == 1) sc[1] = sat_add(sc[1], 1);
            run_sj = 0;
            if ((c >= 8'h81 && c <= 8'h9f) || (c >= 8'he0 && c <= 8'hfc)) begin
               if (avail >= 1) begin
                  if (n1 >= 8'h40 && n1 <= 8'hfc && n1 != 8'h7f) begin
                     sc[0] = sat_add(sc[0], 16); skip_sj = 1;
                  end else sc[1] = sat_add(sc[1], 256);
               end
            end else if (c[7]) sc[1] = sat_add(sc[1], 256);
         end
      end

      if (skip_eu > 0) begin
         skip_eu--;
      end else if (c == 8'h8e) begin
         if (avail >= 1) begin
            if (kana_b(n1)) begin
               sc[2] = sat_add(sc[2], 10); skip_eu = 1;
               if (run_eu < 2) run_eu++;
            end else sc[3] = sat_add(sc[3], 256);
         end
      end else begin
         if (run_eu == 1) sc[3] = sat_add(sc[3], 1);
         run_eu = 0;
         if (euc_b(c)) begin
            if (avail >= 1) begin
               if (euc_b(n1)) begin
                  sc[2] = sat_add(sc[2], 16); skip_eu = 1;
               end else sc[3] = sat_add(sc[3], 256);
            end
         end else if (c == 8'h8f) begin
            if (avail >= 2) begin
               if (euc_b(n1) && euc_b(n2)) begin
                  sc[2] = sat_add(sc[2], 16); skip_eu = 2;
               end else sc[3] = sat_add(sc[3], 100);
            end
         end else if (c[7]) sc[3] = sat_add(sc[3], 256);
      end

      if (skip_u8 > 0) begin
         skip_u8--;
      end else if (c >= 8'hc0 && c <= 8'hdf) begin
         if (avail >= 1) begin
            if (u8t_b(n1)) begin
               sc[4] = sat_add(sc[4], 10); skip_u8 = 1;
            end else sc[5] = sat_add(sc[5], 100);
         end
      end else if (c >= 8'he0 && c <= 8'hef) begin
         if (avail >= 2) begin
            if (u8t_b(n1) && u8t_b(n2)) begin
               sc[4] = sat_add(sc[4], 15); skip_u8 = 2;
            end else sc[5] = sat_add(sc[5], 1000);
         end
      end else if (c[7]) sc[5] = sat_add(sc[5], 1000);
   endtask

   // Sign of the net-score difference, exact in 65 bits
   function automatic int net_sign(input logic [63:0] a, input logic [63:0] b,
                                   input logic [63:0] c, input logic [63:0] d);
      logic [64:0] l, r;
      l = {1'b0, a} + {1'b0, d};
      r = {1'b0, b} + {1'b0, c};
      return (l > r) ? 1 : (l < r) ? -1 : 0;
   endfunction

   function automatic jteg_enc_type verdict();
      int se, su, eu;
      if (n_seen >= 2 && head_bytes[0] == 8'hff && head_bytes[1] == 8'hfe) return EncUtf16le;
      if (n_seen >= 2 && head_bytes[0] == 8'hfe && head_bytes[1] == 8'hff) return EncUtf16be;
      if (n_seen >= 3 && head_bytes[0] == 8'hef && head_bytes[1] == 8'hbb &&
          head_bytes[2] == 8'hbf) return EncUtf8Bom;
      if (!any_high) return any_esc ? EncJis : EncAscii;
      se = net_sign(sc[0], sc[1], sc[2], sc[3]);
      su = net_sign(sc[0], sc[1], sc[4], sc[5]);
      eu = net_sign(sc[2], sc[3], sc[4], sc[5]);
      if (se > 0 && su > 0) return EncSjis;
      if (se > 0 && su < 0) return EncUtf8;
      if (se < 0 && eu > 0) return EncEucjp;
      if (se < 0 && eu < 0) return EncUtf8;
      return EncUnknown;
   endfunction

   // Advance the predictor by one accepted byte
   task automatic predict_byte(input logic [7:0] b, input bit fin);
      int held;
      held = (n_seen < 2) ? n_seen : 2;
      if (b[7]) any_high = 1;
      if (b == ByteEsc) any_esc = 1;
      if (n_seen < 3) head_bytes[n_seen] = b;
      if (held == 2) begin
         score_position(win[0], win[1], b, 2);
         win[0] = win[1]; win[1] = b;
      end else begin
         win[held] = b; held++;
      end
      if (n_seen < 3) n_seen++;
      if (fin) begin
         if (held == 2) begin
            score_position(win[0], win[1], 8'h00, 1);
            score_position(win[1], 8'h00, 8'h00, 0);
         end else score_position(win[0], 8'h00, 8'h00, 0);
         expected_codes.push_back(verdict());
         clear_text();
      end
   endtask

   // Send one byte beat, with bursty gaps when enabled; valid drops only in a gap
   task automatic send_byte(input logic [7:0] b, input bit fin);
      if (burst_mode && $urandom_range(0, 9) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_byte(b, fin);
      @(negedge clock);
   endtask

   task automatic send_text(input logic [7:0] t [$]);
      for (int k = 0; k < t.size(); k++) send_byte(t[k], k == t.size() - 1);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_codes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Receiver stall pattern
   always @(negedge clock) begin
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= (cycles % 11) > 5;
      endcase
   end

   // Check each result beat against the oldest expectation
   always @(posedge clock) begin
      jteg_enc_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_codes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d", $time, rsp_encoding);
            errors++;
         end else begin
            want = expected_codes.pop_front();
            if (rsp_encoding !== want) begin
               $display("%0t: encoding mismatch, expected %0d, actual %0d",
                        $time, want, rsp_encoding);
               errors++;
            end
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic test_marks_and_short();
      send_text('{8'hff, 8'hfe});
      send_text('{8'hfe, 8'hff, 8'h41});
      send_text('{8'hef, 8'hbb, 8'hbf});
      send_text('{8'hef, 8'hbb});
      send_text('{8'hff});
      send_text('{8'h00});
      send_text('{8'h41, 8'h7f, 8'h20});
      send_text('{8'h1b, 8'h24, 8'h42});
   endtask

   task automatic test_scanners();
      send_text('{8'h82, 8'ha0, 8'h83, 8'h40});
      send_text('{8'ha4, 8'ha2, 8'h8f, 8'ha1, 8'ha1});
      send_text('{8'he3, 8'h81, 8'h82, 8'hc3, 8'ha9});
      send_text('{8'h8e, 8'hb1, 8'h8e});
      send_text('{8'h41, 8'hb1});
      send_text('{8'hb1, 8'h41, 8'hb1, 8'hb2, 8'h41});
      send_text('{8'h80, 8'h80});
      send_text('{8'ha4, 8'ha2, 8'hc3, 8'ha9});
      send_text('{8'h8f, 8'h41, 8'h41, 8'he3, 8'h41});
   endtask

   function automatic logic [7:0] rand_byte(input int mode);
      case (mode)
         0: return 8'($urandom_range(0, 255));
         1: return 8'($urandom_range(8'h81, 8'hfc));
         2: return 8'($urandom_range(8'ha1, 8'hfe));
         3: return 8'($urandom_range(8'h80, 8'hbf));
         default: return 8'($urandom_range(8'h20, 8'h7e));
      endcase
   endfunction

   // Random texts biased toward well-formed sequences of each encoding
   task automatic test_random(input int n_bytes);
      logic [7:0] t [$];
      int sent, len, flavour;
      sent = 0;
      while (sent < n_bytes) begin
         t.delete();
         len = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 3) : $urandom_range(2, 24);
         flavour = $urandom_range(0, 4);
         while (t.size() < len) begin
            case (flavour)
               0: begin t.push_back(rand_byte(1)); t.push_back(8'($urandom_range(8'h40, 8'hfc))); end
               1: if ($urandom_range(0, 3) == 0) begin
                     t.push_back(8'h8e); t.push_back(8'($urandom_range(8'ha0, 8'hdf)));
                  end else begin t.push_back(rand_byte(2)); t.push_back(rand_byte(2)); end
               2: begin
                     t.push_back(8'($urandom_range(8'he0, 8'hef)));
                     t.push_back(rand_byte(3)); t.push_back(rand_byte(3));
                  end
               3: t.push_back(($urandom_range(0, 4) == 0) ? ByteEsc : rand_byte(4));
               default: t.push_back(rand_byte(0));
            endcase
            if ($urandom_range(0, 7) == 0) t.push_back(rand_byte(0));
         end
         sent += t.size();
         send_text(t);
      end
   endtask

   initial begin
      clear_text();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      burst_mode = 1'b0;
      stall_mode = 0;
      test_marks_and_short();
      test_scanners();
      wait_drained();
      burst_mode = 1'b1;
      stall_mode = 1;
      test_random(940);
      wait_drained();
      burst_mode = 1'b0;
      stall_mode = 2;
      test_random(940);
      wait_drained();
      repeat (10) @(negedge clock);
      if (errors == 0 && expected_codes.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
